// File: hdl/fecs_pkg.sv
// ----------------------------------------------------------------------------
// fecs_pkg - shared types and constants of the frame encoder
// Command format between the front end and the byte sequencer, escape bytes,
// register map and reset values.
// ----------------------------------------------------------------------------
package fecs_pkg;

  // escape rule: a wire byte equal to ESC_TRIGGER is followed by ESC_FILL
  localparam logic [7:0] ESC_TRIGGER = 8'h81;
  localparam logic [7:0] ESC_FILL    = 8'hFF;

  // defaults for top-level parameters
  localparam int MIN_FRAME_BYTES_DEF = 14;
  localparam int QUEUE_DEPTH_DEF     = 4;

  // register file
  localparam int         ADDR_W           = 3;
  localparam int         PDATA_W          = 32;
  localparam logic       REG_START_MARKER = 1'b0;  // byte address 0
  localparam logic       REG_CRC_DIVISOR  = 1'b1;  // byte address 4
  localparam logic [7:0] START_MARKER_RST = 8'h7E;
  localparam logic [7:0] CRC_DIVISOR_RST  = 8'h07;

  // request kinds on the input tuser bit
  localparam logic REQ_HEADER = 1'b0;
  localparam logic REQ_DATA   = 1'b1;

  // input tdata layout
  localparam int IN_DATA_W = 24;

  typedef enum logic [1:0] {
    CMD_HDR  = 2'd0,
    CMD_DATA = 2'd1,
    CMD_DROP = 2'd2
  } cmd_kind_t;

  // one classified request; byte_a carries the payload byte on data commands
  typedef struct packed {
    cmd_kind_t  kind;
    logic [7:0] byte_a;
    logic [7:0] byte_b;
    logic       finish;   // frame closes after this command: CRC and padding
  } cmd_t;

endpackage

// File: hdl/frame_encoder_crc8_stuffing.sv
// ----------------------------------------------------------------------------
// frame_encoder_crc8_stuffing - framed packet encoder with CRC-8 and stuffing
// Turns header and payload requests into a byte stream: marker, two header
// bytes, payload, CRC and zero padding, with 0xFF inserted after every 0x81.
//
//   channel  dir  handshake          payload
//   s_*      in   s_tvalid/s_tready  tdata: frame_type, seq_number,
//                                    frame_length, data_byte; tuser: req_type
//   m_*      out  m_tvalid/m_tready  tdata: byte_out; tlast: frame_end;
//                                    tuser: item_dropped
//   apb      in   psel/penable       0x0 start_marker, 0x4 crc_divisor
//
// The byte sequencer puts out one wire byte per clock. A data request gives
// one byte (two when it is escaped); a header gives three plus escapes;
// a closing request adds the CRC and padding bytes. Requests queue in a
// QUEUE_DEPTH command queue, so s_tready drops only when it is full.
// Reset is synchronous and empties the queue and the sequencer; registers
// return to 0x7E and 0x07. m_tready low freezes the sequencer only.
// ----------------------------------------------------------------------------
module frame_encoder_crc8_stuffing #(
  parameter int MIN_FRAME_BYTES = fecs_pkg::MIN_FRAME_BYTES_DEF,
  parameter int QUEUE_DEPTH     = fecs_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  // input requests
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [fecs_pkg::IN_DATA_W-1:0] s_tdata,  // frame_type, seq_number,
                                                   // frame_length, data_byte
  input  logic                           s_tuser,  // req_type
  // wire bytes
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [7:0]                     m_tdata,  // byte_out
  output logic                           m_tlast,  // frame_end
  output logic                           m_tuser,  // item_dropped
  // configuration
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [fecs_pkg::ADDR_W-1:0]    paddr,
  input  logic [fecs_pkg::PDATA_W-1:0]   pwdata,
  output logic [fecs_pkg::PDATA_W-1:0]   prdata,
  output logic                           pready
);

  logic [7:0]     start_marker;
  logic [7:0]     crc_divisor;
  logic           cfg_wr;

  logic           q_full;
  logic           q_push;
  fecs_pkg::cmd_t q_push_data;
  logic           q_empty;
  logic           q_pop;
  fecs_pkg::cmd_t q_head;

  // register file
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_marker <= fecs_pkg::START_MARKER_RST;
      crc_divisor  <= fecs_pkg::CRC_DIVISOR_RST;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        fecs_pkg::REG_START_MARKER: start_marker <= pwdata[7:0];
        fecs_pkg::REG_CRC_DIVISOR:  crc_divisor  <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      fecs_pkg::REG_START_MARKER: prdata = {{(fecs_pkg::PDATA_W-8){1'b0}}, start_marker};
      fecs_pkg::REG_CRC_DIVISOR:  prdata = {{(fecs_pkg::PDATA_W-8){1'b0}}, crc_divisor};
      default:                    prdata = '0;
    endcase
  end

  fecs_front u_front (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_push_data (q_push_data)
  );

  fecs_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_push_data),
    .full      (q_full),
    .pop       (q_pop),
    .head      (q_head),
    .empty     (q_empty)
  );

  fecs_back #(
    .MIN_FRAME_BYTES (MIN_FRAME_BYTES)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .start_marker (start_marker),
    .crc_divisor  (crc_divisor),
    .q_empty      (q_empty),
    .q_head       (q_head),
    .q_pop        (q_pop),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .m_tdata      (m_tdata),
    .m_tlast      (m_tlast),
    .m_tuser      (m_tuser)
  );

endmodule

// File: hdl/fecs_front.sv
// ----------------------------------------------------------------------------
// fecs_front - request classifier
// Accepts input requests, tracks the open frame's remaining payload count and
// turns each request into a header, data or drop command for the queue.
// ----------------------------------------------------------------------------
module fecs_front (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [fecs_pkg::IN_DATA_W-1:0] s_tdata,
  input  logic                           s_tuser,
  input  logic                           q_full,
  output logic                           q_push,
  output fecs_pkg::cmd_t                 q_push_data
);

  // payload bytes still expected; nonzero means a frame is open
  logic [5:0] payload_left;
  logic [5:0] payload_left_next;

  logic [4:0] frame_type;
  logic [4:0] seq_number;
  logic [5:0] frame_length;
  logic [7:0] data_byte;

  assign frame_type   = s_tdata[4:0];
  assign seq_number   = s_tdata[9:5];
  assign frame_length = s_tdata[15:10];
  assign data_byte    = s_tdata[23:16];

  assign s_tready = !q_full;
  assign q_push   = s_tvalid && !q_full;

  // classify the request
  always_comb begin
    q_push_data       = '{kind: fecs_pkg::CMD_DROP, byte_a: 8'h00, byte_b: 8'h00,
                          finish: 1'b0};
    payload_left_next = payload_left;
    if (s_tuser == fecs_pkg::REQ_HEADER) begin
      // header: a new frame, abandoning any unfinished one
      q_push_data.kind   = fecs_pkg::CMD_HDR;
      q_push_data.byte_a = {frame_length, seq_number[4:3]};
      q_push_data.byte_b = {seq_number[2:0], frame_type};
      q_push_data.finish = (frame_length == 6'd0);
      payload_left_next  = frame_length;
    end else if (payload_left != 6'd0) begin
      q_push_data.kind   = fecs_pkg::CMD_DATA;
      q_push_data.byte_a = data_byte;
      q_push_data.finish = (payload_left == 6'd1);
      payload_left_next  = payload_left - 6'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      payload_left <= 6'd0;
    end else if (q_push) begin
      payload_left <= payload_left_next;
    end
  end

endmodule

// File: hdl/fecs_fifo.sv
// ----------------------------------------------------------------------------
// fecs_fifo - command queue
// Small first-in first-out queue of commands between the classifier and the
// byte sequencer. DEPTH is a power of two, at least 2.
// ----------------------------------------------------------------------------
module fecs_fifo #(
  parameter int DEPTH = fecs_pkg::QUEUE_DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  fecs_pkg::cmd_t push_data,
  output logic           full,
  input  logic           pop,
  output fecs_pkg::cmd_t head,
  output logic           empty
);

  localparam int PTR_W = $clog2(DEPTH);

  fecs_pkg::cmd_t mem [DEPTH];
  logic [PTR_W:0] wr_ptr;
  logic [PTR_W:0] rd_ptr;

  assign empty = (wr_ptr == rd_ptr);
  assign full  = (wr_ptr[PTR_W] != rd_ptr[PTR_W]) &&
                 (wr_ptr[PTR_W-1:0] == rd_ptr[PTR_W-1:0]);
  assign head  = mem[rd_ptr[PTR_W-1:0]];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr[PTR_W-1:0]] <= push_data;
    end
  end

  // pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + (PTR_W+1)'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + (PTR_W+1)'(1);
      end
    end
  end

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("queue popped while empty");
  a_no_push_full: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("queue pushed while full");

endmodule

// File: hdl/fecs_back.sv
// ----------------------------------------------------------------------------
// fecs_back - byte sequencer
// Expands queued commands into bytes, one per cycle unless stalled: marker,
// header, payload, CRC, zero padding, a fill byte after each escape trigger.
// Keeps the running CRC and the unstuffed byte count of the current frame.
// ----------------------------------------------------------------------------
module fecs_back #(
  parameter int MIN_FRAME_BYTES = fecs_pkg::MIN_FRAME_BYTES_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic [7:0]     start_marker,
  input  logic [7:0]     crc_divisor,
  input  logic           q_empty,
  input  fecs_pkg::cmd_t q_head,
  output logic           q_pop,
  output logic           m_tvalid,
  input  logic           m_tready,
  output logic [7:0]     m_tdata,
  output logic           m_tlast,
  output logic           m_tuser
);

  localparam int             CNT_W   = $clog2(MIN_FRAME_BYTES + 1);
  localparam logic [CNT_W-1:0] MIN_CNT = CNT_W'(MIN_FRAME_BYTES);

  typedef enum logic [8:0] {
    ST_IDLE = 9'b000000001,
    ST_MARK = 9'b000000010,
    ST_HA   = 9'b000000100,
    ST_HB   = 9'b000001000,
    ST_DATA = 9'b000010000,
    ST_CRC  = 9'b000100000,
    ST_PAD  = 9'b001000000,
    ST_DROP = 9'b010000000,
    ST_FILL = 9'b100000000
  } state_t;

  // xor-then-shift CRC step over one byte
  function automatic logic [7:0] crc_feed(input logic [7:0] rem, input logic [7:0] b,
                                          input logic [7:0] div);
    logic [7:0] r;
    r = rem ^ b;
    for (int i = 0; i < 8; i++) begin
      if (r[7]) begin
        r = r ^ div;
      end
      r = {r[6:0], 1'b0};
    end
    return r;
  endfunction

  state_t         state;
  state_t         state_next;
  state_t         after;       // where to go once the fill byte is out
  state_t         step_nxt;
  state_t         state_step;
  state_t         first_state;
  fecs_pkg::cmd_t cur;
  logic [7:0]     crc_rem;
  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] cnt_inc;
  logic           pad_more;

  logic [7:0]     emit_byte;
  logic           counted;
  logic           feed;
  logic           is_drop;
  logic           is_stuff;
  logic           emit_end;
  logic           out_free;
  logic           adv;
  logic           emitting;
  logic           load;

  logic           o_valid;
  logic [7:0]     o_byte;
  logic           o_end;
  logic           o_drop;

  assign out_free = !o_valid || m_tready;
  assign cnt_inc  = (cnt < MIN_CNT) ? cnt + CNT_W'(1) : cnt;
  assign pad_more = (cnt_inc < MIN_CNT);

  // byte of the current step and the step that follows it
  always_comb begin
    emit_byte = 8'h00;
    counted   = 1'b0;
    feed      = 1'b0;
    is_drop   = 1'b0;
    step_nxt  = ST_IDLE;
    unique case (state)
      ST_IDLE: begin
        step_nxt = ST_IDLE;
      end
      ST_MARK: begin
        emit_byte = start_marker;
        counted   = 1'b1;
        step_nxt  = ST_HA;
      end
      ST_HA: begin
        emit_byte = cur.byte_a;
        counted   = 1'b1;
        feed      = 1'b1;
        step_nxt  = ST_HB;
      end
      ST_HB: begin
        emit_byte = cur.byte_b;
        counted   = 1'b1;
        feed      = 1'b1;
        step_nxt  = cur.finish ? ST_CRC : ST_IDLE;
      end
      ST_DATA: begin
        emit_byte = cur.byte_a;
        counted   = 1'b1;
        feed      = 1'b1;
        step_nxt  = cur.finish ? ST_CRC : ST_IDLE;
      end
      ST_CRC: begin
        emit_byte = crc_rem;
        counted   = 1'b1;
        step_nxt  = pad_more ? ST_PAD : ST_IDLE;
      end
      ST_PAD: begin
        counted  = 1'b1;
        step_nxt = pad_more ? ST_PAD : ST_IDLE;
      end
      ST_DROP: begin
        is_drop  = 1'b1;
        step_nxt = ST_IDLE;
      end
      ST_FILL: begin
        emit_byte = fecs_pkg::ESC_FILL;
        step_nxt  = after;
      end
      default: begin
        step_nxt = ST_IDLE;
      end
    endcase
  end

  // escape insertion and frame end
  assign is_stuff   = counted && (emit_byte == fecs_pkg::ESC_TRIGGER);
  assign state_step = is_stuff ? ST_FILL : step_nxt;
  assign emit_end   = (state_step == ST_IDLE) && cur.finish;

  // first step of the command at the queue head
  always_comb begin
    unique case (q_head.kind)
      fecs_pkg::CMD_HDR:  first_state = ST_MARK;
      fecs_pkg::CMD_DATA: first_state = ST_DATA;
      default:            first_state = ST_DROP;
    endcase
  end

  // advance when idle or when the output register can take a byte
  assign adv      = (state == ST_IDLE) || out_free;
  assign emitting = (state != ST_IDLE) && out_free;
  assign load     = adv && (state_step == ST_IDLE) && !q_empty;
  assign q_pop    = load;

  always_comb begin
    if (!adv) begin
      state_next = state;
    end else if (load) begin
      state_next = first_state;
    end else begin
      state_next = state_step;
    end
  end

  // sequencer, CRC, count and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      o_valid <= 1'b0;
      crc_rem <= 8'h00;
      cnt     <= '0;
    end else begin
      state <= state_next;
      if (emitting) begin
        o_valid <= 1'b1;
        o_byte  <= emit_byte;
        o_end   <= emit_end;
        o_drop  <= is_drop;
      end else if (m_tready) begin
        o_valid <= 1'b0;
      end
      if (load && q_head.kind == fecs_pkg::CMD_HDR) begin
        // a new frame restarts the CRC and the byte count
        crc_rem <= 8'h00;
        cnt     <= '0;
      end else begin
        if (emitting && feed) begin
          crc_rem <= crc_feed(crc_rem, emit_byte, crc_divisor);
        end
        if (emitting && counted) begin
          cnt <= cnt_inc;
        end
      end
      if (emitting && is_stuff) begin
        after <= step_nxt;
      end
      if (load) begin
        cur <= q_head;
      end
    end
  end

  assign m_tvalid = o_valid;
  assign m_tdata  = o_byte;
  assign m_tlast  = o_end;
  assign m_tuser  = o_drop;

  a_fill_after_trigger: assert property (@(posedge clk) disable iff (rst)
    state == ST_FILL |-> m_tvalid && m_tdata == fecs_pkg::ESC_TRIGGER)
    else $error("fill byte pending without a trigger byte in the output register");
  a_drop_shape: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata == 8'h00 && !m_tlast)
    else $error("drop result carries data or frame end");
  a_stall_holds_step: assert property (@(posedge clk) disable iff (rst)
    state != ST_IDLE && !out_free |=> state == $past(state))
    else $error("sequencer moved while output stalled");

endmodule

// File: tb/frame_stream_checker.sv
// ----------------------------------------------------------------------------
// frame_stream_checker - wire byte predictor and comparator
// Watches the request channel, the wire byte channel and the register port of
// the frame encoder. Every accepted request is turned into the wire bytes it
// must produce, and every accepted wire byte is checked against the oldest
// one still outstanding.
// ----------------------------------------------------------------------------
module frame_stream_checker #(
  parameter int MIN_FRAME_BYTES = fecs_pkg::MIN_FRAME_BYTES_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  input  logic                           s_tready,
  input  logic [fecs_pkg::IN_DATA_W-1:0] s_tdata,   // frame_type, seq_number,
                                                    // frame_length, data_byte
  input  logic                           s_tuser,   // req_type
  input  logic                           m_tvalid,
  input  logic                           m_tready,
  input  logic [7:0]                     m_tdata,   // byte_out
  input  logic                           m_tlast,   // frame_end
  input  logic                           m_tuser,   // item_dropped
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [fecs_pkg::ADDR_W-1:0]    paddr,
  input  logic [fecs_pkg::PDATA_W-1:0]   pwdata,
  input  logic                           pready,
  output int                             mismatches,
  output int                             pending
);

  typedef struct packed {
    logic [7:0] wire_byte;
    logic       frame_end;
    logic       dropped;
  } wire_beat_t;

  wire_beat_t  expected_beats[$];

  // shadow registers and encoder state
  logic [7:0]  marker;
  logic [7:0]  divisor;
  logic [7:0]  crc_rem;
  logic [5:0]  payload_left;
  int unsigned frame_bytes;
  logic        frame_open;

  // xor first, then shift: the divisor is applied before the bit leaves
  function automatic logic [7:0] crc_step(input logic [7:0] rem, input logic [7:0] din,
                                          input logic [7:0] div);
    logic [7:0] r;
    r = rem ^ din;
    for (int i = 0; i < 8; i++) begin
      if (r[7]) r = r ^ div;
      r = r << 1;
    end
    return r;
  endfunction

  // one unstuffed byte, plus its escape fill on the wire
  task automatic put_wire_byte(input logic [7:0] b);
    expected_beats.push_back('{wire_byte: b, frame_end: 1'b0, dropped: 1'b0});
    if (b == fecs_pkg::ESC_TRIGGER)
      expected_beats.push_back('{wire_byte: fecs_pkg::ESC_FILL, frame_end: 1'b0,
                                 dropped: 1'b0});
    if (frame_bytes < MIN_FRAME_BYTES) frame_bytes++;
  endtask

  // CRC, zero padding up to the minimum size, end flag on the last wire byte
  task automatic close_frame();
    put_wire_byte(crc_rem);
    while (frame_bytes < MIN_FRAME_BYTES) put_wire_byte(8'h00);
    expected_beats[expected_beats.size() - 1].frame_end = 1'b1;
    frame_open   = 1'b0;
    payload_left = '0;
  endtask

  task automatic encode_request(input logic kind,
                                input logic [fecs_pkg::IN_DATA_W-1:0] req);
    logic [4:0] ftype;
    logic [4:0] seq;
    logic [5:0] len;
    logic [7:0] hdr_a;
    logic [7:0] hdr_b;
    ftype = req[4:0];
    seq   = req[9:5];
    len   = req[15:10];
    if (kind == fecs_pkg::REQ_HEADER) begin
      // a header always restarts, abandoning any open frame
      hdr_a        = {len, seq[4:3]};
      hdr_b        = {seq[2:0], ftype};
      crc_rem      = '0;
      frame_bytes  = 0;
      frame_open   = 1'b1;
      payload_left = len;
      put_wire_byte(marker);
      put_wire_byte(hdr_a);
      crc_rem = crc_step(crc_rem, hdr_a, divisor);
      put_wire_byte(hdr_b);
      crc_rem = crc_step(crc_rem, hdr_b, divisor);
      if (payload_left == 0) close_frame();
    end else if (!frame_open) begin
      expected_beats.push_back('{wire_byte: 8'h00, frame_end: 1'b0, dropped: 1'b1});
    end else begin
      put_wire_byte(req[23:16]);
      crc_rem      = crc_step(crc_rem, req[23:16], divisor);
      payload_left = payload_left - 6'd1;
      if (payload_left == 0) close_frame();
    end
  endtask

  always @(posedge clk) begin
    wire_beat_t got;
    wire_beat_t want;
    if (rst) begin
      marker       = fecs_pkg::START_MARKER_RST;
      divisor      = fecs_pkg::CRC_DIVISOR_RST;
      crc_rem      = '0;
      payload_left = '0;
      frame_bytes  = 0;
      frame_open   = 1'b0;
      expected_beats.delete();
    end else begin
      // register writes
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == fecs_pkg::REG_START_MARKER) marker = pwdata[7:0];
        else                                        divisor = pwdata[7:0];
      end
      // accepted request
      if (s_tvalid && s_tready) encode_request(s_tuser, s_tdata);
      // accepted wire byte
      if (m_tvalid && m_tready) begin
        got = '{wire_byte: m_tdata, frame_end: m_tlast, dropped: m_tuser};
        if (expected_beats.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected wire byte %02h last %0b drop %0b", got.wire_byte,
                     got.frame_end, got.dropped);
        end else begin
          want = expected_beats.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("wire byte mismatch: expected %02h last %0b drop %0b, got %02h last %0b drop %0b",
                       want.wire_byte, want.frame_end, want.dropped,
                       got.wire_byte, got.frame_end, got.dropped);
          end
        end
      end
    end
    pending = expected_beats.size();
  end

endmodule

// File: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench - frame encoder with CRC-8 and byte stuffing
// Drives header and payload requests and register writes, with random idle
// bursts on both channels and a long hold-off of the wire byte sink. Checking
// is left to frame_stream_checker; this module gives the verdict.
// ----------------------------------------------------------------------------
module testbench;

  logic                           clk      = 1'b0;
  logic                           rst      = 1'b1;
  logic                           s_tvalid = 1'b0;
  logic                           s_tready;
  logic [fecs_pkg::IN_DATA_W-1:0] s_tdata  = '0;   // frame_type, seq_number,
                                                   // frame_length, data_byte
  logic                           s_tuser  = 1'b0; // req_type
  logic                           m_tvalid;
  logic                           m_tready = 1'b0;
  logic [7:0]                     m_tdata;         // byte_out
  logic                           m_tlast;         // frame_end
  logic                           m_tuser;         // item_dropped
  logic                           psel     = 1'b0;
  logic                           penable  = 1'b0;
  logic                           pwrite   = 1'b0;
  logic [fecs_pkg::ADDR_W-1:0]    paddr    = '0;
  logic [fecs_pkg::PDATA_W-1:0]   pwdata   = '0;
  logic [fecs_pkg::PDATA_W-1:0]   prdata;
  logic                           pready;

  int   mismatches;
  int   pending;
  logic sink_hold = 1'b0;  // asks the sink for one long hold-off
  logic calm      = 1'b0;  // no idling on either side

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  frame_encoder_crc8_stuffing dut (
    .clk, .rst,
    .s_tvalid, .s_tready, .s_tdata, .s_tuser,
    .m_tvalid, .m_tready, .m_tdata, .m_tlast, .m_tuser,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  frame_stream_checker frame_check (
    .clk, .rst,
    .s_tvalid, .s_tready, .s_tdata, .s_tuser,
    .m_tvalid, .m_tready, .m_tdata, .m_tlast, .m_tuser,
    .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .mismatches, .pending
  );

  function automatic logic [fecs_pkg::IN_DATA_W-1:0] pack_req(input logic [4:0] ftype,
                                                              input logic [4:0] seq,
                                                              input logic [5:0] len,
                                                              input logic [7:0] dbyte);
    return {dbyte, len, seq, ftype};
  endfunction

  // payload bytes lean on the escape trigger now and then
  function automatic logic [7:0] payload_byte();
    if ($urandom_range(0, 7) == 0) return fecs_pkg::ESC_TRIGGER;
    return 8'($urandom_range(0, 255));
  endfunction

  // one request, with an optional idle burst in front of it
  task automatic send_req(input logic kind, input logic [fecs_pkg::IN_DATA_W-1:0] req);
    int gap;
    gap = (!calm && $urandom_range(0, 4) == 0) ? $urandom_range(1, 13) : 0;
    @(negedge clk);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= req;
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic send_header(input logic [4:0] ftype, input logic [4:0] seq,
                             input logic [5:0] len);
    send_req(fecs_pkg::REQ_HEADER, pack_req(ftype, seq, len, 8'($urandom_range(0, 255))));
  endtask

  task automatic send_data(input logic [7:0] dbyte);
    send_req(fecs_pkg::REQ_DATA, pack_req(5'($urandom_range(0, 31)),
                                          5'($urandom_range(0, 31)),
                                          6'($urandom_range(0, 63)), dbyte));
  endtask

  // stop offering and wait for every outstanding wire byte
  task automatic wait_idle(input int settle);
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (settle) @(negedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [7:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {24'd0, value};
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_regs(input logic [7:0] marker, input logic [7:0] divisor);
    write_reg(fecs_pkg::REG_START_MARKER, marker);
    write_reg(fecs_pkg::REG_CRC_DIVISOR, divisor);
  endtask

  // mostly whole frames; some cut short by the next header, some stray data
  task automatic random_frames(input int target);
    int sent;
    int len;
    int body;
    sent = 0;
    while (sent < target) begin
      len = ($urandom_range(0, 11) == 0) ? $urandom_range(20, 63) : $urandom_range(0, 10);
      send_header(5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)), 6'(len));
      body = ($urandom_range(0, 7) == 0) ? $urandom_range(0, len) : len;
      for (int i = 0; i < body; i++) send_data(payload_byte());
      sent += 1 + body;
      if (body == len && $urandom_range(0, 5) == 0) begin
        send_data(payload_byte());
        sent++;
      end
    end
  endtask

  // wire byte sink: random stalls, one long hold-off on request
  initial begin
    forever begin
      @(negedge clk);
      if (sink_hold) begin
        m_tready <= 1'b0;
        repeat (150) @(negedge clk);
        sink_hold = 1'b0;
        m_tready <= 1'b1;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(negedge clk);
        m_tready <= 1'b1;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  initial begin
    #4_000_000;
    $display("** frame_encoder_crc8_stuffing: FAILED **");
    $finish;
  end

  initial begin
    repeat (8) @(negedge clk);
    rst <= 1'b0;

    // directed requests at reset register values
    send_data(8'h55);                        // no frame open: dropped
    send_header(5'd31, 5'd31, 6'd0);         // empty payload
    send_header(5'd0, 5'd0, 6'd2);
    send_data(fecs_pkg::ESC_TRIGGER);
    send_data(8'hFF);
    send_header(5'd21, 5'd10, 6'd5);
    send_data(8'h00);
    send_data(8'hA5);
    send_header(5'd10, 5'd21, 6'd1);         // abandons the open frame
    send_data(8'h3C);
    send_header(5'd3, 5'd7, 6'd11);          // long enough for no padding
    for (int i = 0; i < 11; i++) send_data(payload_byte());
    send_data(8'h12);                        // after close: dropped
    random_frames(24);

    // escape trigger as marker and as both header bytes; sink held off
    wait_idle(4);
    set_regs(fecs_pkg::ESC_TRIGGER, 8'h00);
    sink_hold = 1'b1;
    send_header(5'd1, 5'd12, 6'd32);
    for (int i = 0; i < 32; i++) send_data(payload_byte());
    random_frames(16);

    wait_idle(4);
    set_regs(8'h00, 8'hFF);
    random_frames(20);

    // longest payload
    wait_idle(4);
    set_regs(8'hFF, 8'h80);
    send_header(5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)), 6'd63);
    for (int i = 0; i < 63; i++) send_data(payload_byte());
    random_frames(12);

    // final stretch without idling
    wait_idle(4);
    calm = 1'b1;
    set_regs(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    random_frames(28);

    wait_idle(20);
    if (mismatches == 0 && pending == 0) begin
      $display("** frame_encoder_crc8_stuffing: PASSED **");
    end else begin
      $display("** frame_encoder_crc8_stuffing: FAILED **");
    end
    $finish;
  end

endmodule

// File: files.f
hdl/fecs_pkg.sv
hdl/fecs_front.sv
hdl/fecs_fifo.sv
hdl/fecs_back.sv
hdl/frame_encoder_crc8_stuffing.sv
tb/frame_stream_checker.sv
tb/testbench.sv
